### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. They expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

### rtl/core/alst_pkg.sv
`default_nettype none

package alst_pkg;

	localparam int CAPACITY    = 16;
	localparam int ENTRY_WIDTH = 32;

	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W   = $clog2(CAPACITY);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_REPLACE = 3'd2,
		CMD_READ    = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} stat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

endpackage

`default_nettype wire

### rtl/core/array_list_engine.sv
// Channel    Handshake              Ports
// ---------  ---------------------  ----------------------------------------------
// command    start high, busy low   command, position, entry_data
// result     done, one-cycle pulse  read_data, status, entry_count, full_flag,
//                                   empty_flag
//
// A command is captured on the accepting edge and executed in the next cycle,
// where the whole register row shifts at once; the result is shown in the
// cycle after that. busy is high for one cycle per transaction, and no new
// command is taken while it is high, in the execute state.
// Reset clears the count and the controller; list entries are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none

`include "assert_macros.svh"

module array_list_engine
	import alst_pkg::*;
#(
	parameter int ENTRY_W = ENTRY_WIDTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [CMD_W-1:0]   command,
	input  wire  [POS_W-1:0]   position,
	input  wire  [DATA_W-1:0]  entry_data,
	output logic               done,
	output logic [DATA_W-1:0]  read_data,
	output logic [STAT_W-1:0]  status,
	output logic [COUNT_W-1:0] entry_count,
	output logic               full_flag,
	output logic               empty_flag
);

	ctl_t ctl;

	alst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	alst_dp #(
		.ENTRY_W (ENTRY_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.command     (command),
		.position    (position),
		.entry_data  (entry_data),
		.read_data   (read_data),
		.status      (status),
		.entry_count (entry_count),
		.full_flag   (full_flag),
		.empty_flag  (empty_flag)
	);

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`ASSERT_NEXT(a_exec_done, busy, done && !busy)
	`ASSERT_SAME(a_full_status, done && (status == ST_FULL), full_flag)
	`ASSERT_SAME(a_fail_no_data, done && (status != ST_OK), read_data == '0)
	`ASSERT_ALWAYS(a_flags_excl, !(full_flag && empty_flag))

endmodule

`default_nettype wire

### rtl/core/alst_ctrl.sv
`default_nettype none

module alst_ctrl
	import alst_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	output logic busy,
	output logic done,
	output ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctl.exec;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

### rtl/core/alst_dp.sv
`default_nettype none

module alst_dp
	import alst_pkg::*;
#(
	parameter int ENTRY_W = ENTRY_WIDTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  ctl_t               ctl,
	input  wire  [CMD_W-1:0]   command,
	input  wire  [POS_W-1:0]   position,
	input  wire  [DATA_W-1:0]  entry_data,
	output logic [DATA_W-1:0]  read_data,
	output logic [STAT_W-1:0]  status,
	output logic [COUNT_W-1:0] entry_count,
	output logic               full_flag,
	output logic               empty_flag
);

	localparam int CMP_W = (POS_W > COUNT_W) ? POS_W : COUNT_W;

	logic [CMD_W-1:0]   cmd_q;
	logic [POS_W-1:0]   pos_q;
	logic [ENTRY_W-1:0] data_q;
	logic [COUNT_W-1:0] count_q;
	logic [ENTRY_W-1:0] entries_q [CAPACITY];
	logic [DATA_W-1:0]  read_data_q;
	stat_t              status_q;

	logic [IDX_W-1:0]   idx;
	logic [CMP_W-1:0]   pos_c;
	logic [CMP_W-1:0]   cnt_c;
	logic [63:0]        rd_wide;
	logic [63:0]        in_wide;
	logic [COUNT_W-1:0] count_d;
	logic [DATA_W-1:0]  rd_d;
	stat_t              st_d;
	logic               ins_en;
	logic               rem_en;
	logic               rep_en;

	assign idx     = pos_q[IDX_W-1:0];
	assign pos_c   = CMP_W'(pos_q);
	assign cnt_c   = CMP_W'(count_q);
	assign rd_wide = 64'(entries_q[idx]);
	assign in_wide = 64'(entry_data);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			pos_q  <= position;
			data_q <= in_wide[ENTRY_W-1:0];
		end
	end

	always_comb begin
		count_d = count_q;
		rd_d    = '0;
		st_d    = ST_OK;
		ins_en  = 1'b0;
		rem_en  = 1'b0;
		rep_en  = 1'b0;
		unique case (cmd_q)
			CMD_INSERT: begin
				// The range test takes precedence over the full test.
				if (pos_c > cnt_c) begin
					st_d = ST_RANGE;
				end else if (count_q == COUNT_W'(CAPACITY)) begin
					st_d = ST_FULL;
				end else begin
					ins_en  = 1'b1;
					count_d = count_q + COUNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (pos_c >= cnt_c) begin
					st_d = ST_RANGE;
				end else begin
					rem_en  = 1'b1;
					rd_d    = rd_wide[DATA_W-1:0];
					count_d = count_q - COUNT_W'(1);
				end
			end
			CMD_REPLACE: begin
				if (pos_c >= cnt_c) begin
					st_d = ST_RANGE;
				end else begin
					rep_en = 1'b1;
				end
			end
			CMD_READ: begin
				if (pos_c >= cnt_c) begin
					st_d = ST_RANGE;
				end else begin
					rd_d = rd_wide[DATA_W-1:0];
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Each entry loads new data, its lower neighbor (insert) or its upper
	// neighbor (remove). Entries beyond the count may take garbage; they are
	// never read before being written again.
	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_row
		logic [ENTRY_W-1:0] up_w;
		logic [ENTRY_W-1:0] dn_w;

		if (gi > 0) begin : g_up
			assign up_w = entries_q[gi-1];
		end else begin : g_up0
			assign up_w = data_q;
		end

		if (gi < CAPACITY - 1) begin : g_dn
			assign dn_w = entries_q[gi+1];
		end else begin : g_dnl
			assign dn_w = entries_q[gi];
		end

		always_ff @(posedge clk) begin
			if (ctl.exec) begin
				priority if ((ins_en || rep_en) && (idx == IDX_W'(gi))) begin
					entries_q[gi] <= data_q;
				end else if (ins_en && (idx < IDX_W'(gi))) begin
					entries_q[gi] <= up_w;
				end else if (rem_en && (idx <= IDX_W'(gi))) begin
					entries_q[gi] <= dn_w;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			read_data_q <= rd_d;
			status_q    <= st_d;
		end
	end

	assign read_data   = read_data_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign full_flag   = (count_q == COUNT_W'(CAPACITY));
	assign empty_flag  = (count_q == '0);

endmodule

`default_nettype wire

### tb/tb_array_list_engine.sv
`default_nettype none

module tb_array_list_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import alst_pkg::*;

	localparam int WATCHDOG_LIMIT = 200;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int CALM_TAIL      = 150;
	localparam int PAUSE_AT       = 575;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED  = 2;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] entry_count;
		logic               full_flag;
		logic               empty_flag;
	} list_result_t;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] data;
		int                reps;
		bit                typed;
		list_result_t      want;
	} directed_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [CMD_W-1:0]   command = '0;
	logic [POS_W-1:0]   position = '0;
	logic [DATA_W-1:0]  entry_data = '0;
	logic               busy;
	logic               done;
	logic [DATA_W-1:0]  read_data;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] entry_count;
	logic               full_flag;
	logic               empty_flag;

	// Shadow copy of the list, updated as each command is accepted.
	logic [DATA_W-1:0] shadow_entries [CAPACITY];
	int                shadow_count = 0;

	list_result_t pending_results [$];
	list_result_t oldest_result;
	int           fail_count = 0;
	int           idle_cycles = 0;

	// Rows with a typed result are checked against it; the rest use the shadow list.
	directed_row_t directed_rows [17] = '{
		'{CMD_READ,    5'd0,  32'h0,        1,  1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1}},
		'{CMD_REMOVE,  5'd0,  32'h0,        1,  1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1}},
		'{CMD_REPLACE, 5'd0,  32'hFFFFFFFF, 1,  1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1}},
		'{CMD_INSERT,  5'd1,  32'hFFFFFFFF, 1,  1'b1, '{32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1}},
		'{CMD_SPARE_FIRST, 5'd31, 32'hFFFFFFFF, 1, 1'b1, '{32'h0, ST_OK, 5'd0, 1'b0, 1'b1}},
		'{CMD_SPARE_LAST,  5'd16, 32'h0,        1, 1'b1, '{32'h0, ST_OK, 5'd0, 1'b0, 1'b1}},
		'{CMD_INSERT,  5'd0,  32'hFFFFFFFF, 16, 1'b0, '0},
		'{CMD_INSERT,  5'd16, 32'h1234ABCD, 1,  1'b1, '{32'h0, ST_FULL,  5'd16, 1'b1, 1'b0}},
		'{CMD_INSERT,  5'd0,  32'h1234ABCD, 1,  1'b1, '{32'h0, ST_FULL,  5'd16, 1'b1, 1'b0}},
		'{CMD_INSERT,  5'd17, 32'h1234ABCD, 1,  1'b1, '{32'h0, ST_RANGE, 5'd16, 1'b1, 1'b0}},
		'{CMD_READ,    5'd16, 32'h0,        1,  1'b1, '{32'h0, ST_RANGE, 5'd16, 1'b1, 1'b0}},
		'{CMD_REPLACE, 5'd15, 32'h0,        1,  1'b0, '0},
		'{CMD_READ,    5'd15, 32'h0,        1,  1'b0, '0},
		'{CMD_REMOVE,  5'd31, 32'h0,        1,  1'b1, '{32'h0, ST_RANGE, 5'd16, 1'b1, 1'b0}},
		'{CMD_REMOVE,  5'd15, 32'h0,        1,  1'b0, '0},
		'{CMD_REMOVE,  5'd0,  32'h0,        1,  1'b0, '0},
		'{CMD_CLEAR,   5'd7,  32'h0,        1,  1'b1, '{32'h0, ST_OK,    5'd0,  1'b0, 1'b1}}
	};

	array_list_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.position   (position),
		.entry_data (entry_data),
		.done       (done),
		.read_data  (read_data),
		.status     (status),
		.entry_count(entry_count),
		.full_flag  (full_flag),
		.empty_flag (empty_flag)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic apply_list_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] data, output list_result_t res);
		int i;
		res = '0;
		res.status = ST_OK;
		case (cmd)
			CMD_INSERT: begin
				// The range test wins over the full test.
				if (pos > shadow_count) begin
					res.status = ST_RANGE;
				end else if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[pos] = data;
					shadow_count++;
				end
			end
			CMD_REMOVE, CMD_REPLACE, CMD_READ: begin
				if (pos >= shadow_count) begin
					res.status = ST_RANGE;
				end else if (cmd == CMD_REMOVE) begin
					res.read_data = shadow_entries[pos];
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
				end else if (cmd == CMD_REPLACE) begin
					shadow_entries[pos] = data;
				end else begin
					res.read_data = shadow_entries[pos];
				end
			end
			CMD_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		res.entry_count = shadow_count[COUNT_W-1:0];
		res.full_flag   = (shadow_count == CAPACITY);
		res.empty_flag  = (shadow_count == 0);
	endtask

	// Called at a rising edge; returns at the edge that accepts the transaction.
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] data, input bit typed, input list_result_t want);
		list_result_t predicted;
		start      <= 1'b1;
		command    <= cmd;
		position   <= pos;
		entry_data <= data;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_list_command(cmd, pos, data, predicted);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic pause_sender(input int cycles);
		start      <= 1'b0;
		command    <= CMD_W'($urandom);
		position   <= POS_W'($urandom);
		entry_data <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic pick_random_command(input int mode, output logic [CMD_W-1:0] cmd,
			output logic [POS_W-1:0] pos, output logic [DATA_W-1:0] data);
		int roll;
		int ins_weight;
		int rem_weight;
		int prow;
		int drow;
		ins_weight = (mode == MODE_GROW) ? 65 : (mode == MODE_SHRINK) ? 20 : 35;
		rem_weight = (mode == MODE_GROW) ? 15 : (mode == MODE_SHRINK) ? 60 : 30;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			cmd = CMD_W'(CMD_SPARE_FIRST
				+ $urandom_range(0, CMD_SPARE_LAST - CMD_SPARE_FIRST));
		else if (roll < 4 && mode != MODE_GROW)
			cmd = CMD_CLEAR;
		else if (roll < 4 + ins_weight)
			cmd = CMD_INSERT;
		else if (roll < 4 + ins_weight + rem_weight)
			cmd = CMD_REMOVE;
		else if (roll[0])
			cmd = CMD_REPLACE;
		else
			cmd = CMD_READ;

		// Mostly legal positions, with the first illegal one and arbitrary ones mixed in.
		prow = $urandom_range(0, 99);
		if (prow < 10)
			pos = '0;
		else if (prow < 85)
			pos = POS_W'((cmd == CMD_INSERT) ? $urandom_range(0, shadow_count)
				: (shadow_count > 0 ? $urandom_range(0, shadow_count - 1) : 0));
		else if (prow < 92)
			pos = POS_W'((cmd == CMD_INSERT) ? shadow_count + 1 : shadow_count);
		else
			pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));

		drow = $urandom_range(0, 99);
		if (drow < 5)
			data = '0;
		else if (drow < 10)
			data = '1;
		else
			data = $urandom;
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result seen with no transaction outstanding");
				fail_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("read_data", oldest_result.read_data, read_data);
				check_field("status", DATA_W'(oldest_result.status), DATA_W'(status));
				check_field("entry_count", DATA_W'(oldest_result.entry_count),
					DATA_W'(entry_count));
				check_field("full_flag", DATA_W'(oldest_result.full_flag),
					DATA_W'(full_flag));
				check_field("empty_flag", DATA_W'(oldest_result.empty_flag),
					DATA_W'(empty_flag));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [CMD_W-1:0]  cmd_v;
		logic [POS_W-1:0]  pos_v;
		logic [DATA_W-1:0] data_v;
		int                mode;
		bit                gaps_on;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			for (int k = 0; k < directed_rows[r].reps; k++)
				send_command(directed_rows[r].cmd, directed_rows[r].pos,
					directed_rows[r].data ^ k, directed_rows[r].typed, directed_rows[r].want);

		mode = MODE_GROW;
		gaps_on = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				mode = $urandom_range(MODE_GROW, MODE_MIXED);
				gaps_on = 1'($urandom_range(0, 1));
			end
			pick_random_command(mode, cmd_v, pos_v, data_v);
			send_command(cmd_v, pos_v, data_v, 1'b0, '0);
			if (n == PAUSE_AT) begin
				// Let the engine drain completely before going on.
				pause_sender(1);
				while (pending_results.size() != 0)
					@(posedge clk);
			end else if (gaps_on && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 18));
			end
		end

		pause_sender(1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/alst_pkg.sv
rtl/core/alst_ctrl.sv
rtl/core/alst_dp.sv
rtl/core/array_list_engine.sv
tb/tb_array_list_engine.sv
